// File: hw/rtl/sgm_pkg.sv
// ----------------------------------------------------------------------------
// sgm_pkg: shared types and constants of the Sobel magnitude core
// Pixel and window column types, register indexes, reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package sgm_pkg;

  localparam int unsigned PIX_W         = 8;
  localparam int unsigned MAX_WIDTH_DEF = 1024;

  // configuration register file
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned FW_W       = 11;
  localparam int unsigned FH_W       = 12;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd720;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd540;

  // width arithmetic is done at a size that holds the largest MAX_WIDTH
  localparam int unsigned WCALC_W = 13;
  localparam int unsigned MIN_DIM = 3;

  typedef logic [PIX_W-1:0] pixel_t;

  // one window column, index 0 = oldest row (top), 2 = current row
  typedef pixel_t [2:0] column_t;

endpackage

`default_nettype wire

// File: hw/rtl/sgm_ram.sv
// ----------------------------------------------------------------------------
// sgm_ram: simple dual-port RAM
// One write port, one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sgm_kernel.sv
// ----------------------------------------------------------------------------
// sgm_kernel: 3x3 Sobel magnitude
// (|gx| + |gy|) / 2, truncated, saturated to the pixel range.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_kernel
  import sgm_pkg::*;
(
  input  wire column_t left_col,
  input  wire column_t center_col,
  input  wire column_t right_col,
  output pixel_t       magnitude
);

  logic [9:0]         sum_l, sum_r, sum_t, sum_b;
  logic signed [10:0] gx, gy;
  logic [9:0]         abs_x, abs_y;
  logic [10:0]        abs_sum;
  logic [9:0]         half;

  // column sums weighted 1-2-1 for gx, row sums for gy
  assign sum_l = {2'b00, left_col[0]} + {1'b0, left_col[1], 1'b0} + {2'b00, left_col[2]};
  assign sum_r = {2'b00, right_col[0]} + {1'b0, right_col[1], 1'b0} + {2'b00, right_col[2]};
  assign sum_t = {2'b00, left_col[0]} + {1'b0, center_col[0], 1'b0} + {2'b00, right_col[0]};
  assign sum_b = {2'b00, left_col[2]} + {1'b0, center_col[2], 1'b0} + {2'b00, right_col[2]};

  assign gx = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
  assign gy = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});

  assign abs_x = gx[10] ? 10'(-gx) : gx[9:0];
  assign abs_y = gy[10] ? 10'(-gy) : gy[9:0];

  assign abs_sum = {1'b0, abs_x} + {1'b0, abs_y};
  assign half    = abs_sum[10:1];

  assign magnitude = (|half[9:8]) ? pixel_t'(8'hFF) : half[7:0];

endmodule

`default_nettype wire

// File: hw/rtl/sobel_gradient_magnitude_core.sv
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_core: streaming 3x3 Sobel edge magnitude
// Raster-order grayscale in, (|gx|+|gy|)/2 saturated out, one row of lag.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock and keeps up with a pixel stream at
// full rate: the input register and the line-store read happen in the
// cycle a pixel is transferred, the kernel sits between that stage and
// the output register, which captures each result of the kernel.
// A pixel at (y,x) gives the result for (y-1,x-1); pixels of row 0 and of
// column 0 give none. The last pixel of a row gives two results (the
// interior pixel and the zero at the row end), so the result channel
// needs one extra output slot per row; the column-0 pixel that follows gives no
// result and fills that slot, so in_ready never drops on its own and the
// sustained rate is one pixel per cycle, limited only by out_ready. The two
// line stores are simple dual-port RAMs of MAX_WIDTH entries and need no
// clearing pass after reset. The final image row (all zero) is never
// sent; frame_end marks the last result and the consumer fills that row.
// frame_width is clamped to 3..MAX_WIDTH and frame_height to at least 3;
// write them only while the core is idle. Writes to other indexes are
// accepted and ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_gradient_magnitude_core
  import sgm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,

  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [PIX_W-1:0]      in_pixel,
  input  wire logic                  in_frame_start,

  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [PIX_W-1:0]           out_magnitude,
  output logic                       out_row_end,
  output logic                       out_frame_end,
  output logic                       out_run_last
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size, last column and last row
  logic [WCALC_W-1:0] fw_ext, w_eff;
  logic [COL_W-1:0]   w_m1;
  logic [FH_W-1:0]    h_m1;

  always_comb begin
    fw_ext = WCALC_W'(frame_width_r);
    if (fw_ext < WCALC_W'(MIN_DIM)) begin
      w_eff = WCALC_W'(MIN_DIM);
    end else if (fw_ext > WCALC_W'(MAX_WIDTH)) begin
      w_eff = WCALC_W'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    w_m1 = COL_W'(w_eff - WCALC_W'(1));
    h_m1 = (frame_height_r < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM - 1)
                                             : frame_height_r - FH_W'(1);
  end

  // --------------------------------------------------------------------------
  // handshake control
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  logic s1_has_res_r;
  logic pend_r;
  logic out_valid_r;
  logic out_free;     // output register can take a new first result
  logic s1_go;        // stage 1 item retires this cycle
  logic in_fire;
  logic out_fire;

  assign out_fire = out_valid_r && out_ready;
  assign out_free = !out_valid_r || (out_fire && !pend_r);
  assign s1_go    = s1_valid_r && (!s1_has_res_r || out_free);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_fire  = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // position tracking at the input transfer
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] col_r, col_base, x_in, col_nxt;
  logic [FH_W-1:0]  row_r, row_base, y_in, row_nxt;
  logic             last_col_in;

  always_comb begin
    col_base    = in_frame_start ? '0 : col_r;
    row_base    = in_frame_start ? '0 : row_r;
    x_in        = (col_base < w_m1) ? col_base : w_m1;
    y_in        = (row_base < h_m1) ? row_base : h_m1;
    last_col_in = (x_in == w_m1);
    if (last_col_in) begin
      col_nxt = '0;
      row_nxt = (y_in == h_m1) ? '0 : y_in + FH_W'(1);
    end else begin
      col_nxt = x_in + COL_W'(1);
      row_nxt = y_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: input register, line-store read data arrives alongside
  // --------------------------------------------------------------------------
  pixel_t           s1_pix_r;
  logic [COL_W-1:0] s1_x_r;
  logic             s1_interior_r;   // result is not on a border
  logic             s1_last_col_r;
  logic             s1_last_row_r;   // result row is the last one sent

  // same-address bypass: the previous item writes the slot being read
  logic             fwd_r;
  pixel_t           fwd_top_r, fwd_mid_r;

  pixel_t  ram_top, ram_mid, top, mid;
  column_t win_c1_r, win_c2_r;      // columns x-1 and x-2
  column_t cur_col;
  pixel_t  kern_mag;

  assign top     = fwd_r ? fwd_top_r : ram_top;
  assign mid     = fwd_r ? fwd_mid_r : ram_mid;
  assign cur_col = '{s1_pix_r, mid, top};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r      <= in_pixel;
      s1_x_r        <= x_in;
      s1_has_res_r  <= (x_in != '0) && (y_in != '0);
      s1_interior_r <= (x_in > COL_W'(1)) && (y_in > FH_W'(1));
      s1_last_col_r <= last_col_in;
      s1_last_row_r <= (y_in == h_m1);
      fwd_r         <= s1_go && (x_in == s1_x_r);
      fwd_top_r     <= mid;
      fwd_mid_r     <= s1_pix_r;
    end
  end

  // window shifts once per retired item, whether or not it gives a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_c1_r <= '0;
      win_c2_r <= '0;
    end else if (s1_go) begin
      win_c2_r <= win_c1_r;
      win_c1_r <= cur_col;
    end
  end

  sgm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_older_ram (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_x_r),
    .wr_data (mid),
    .rd_en   (in_fire),
    .rd_addr (x_in),
    .rd_data (ram_top)
  );

  sgm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_newer_ram (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_x_r),
    .wr_data (s1_pix_r),
    .rd_en   (in_fire),
    .rd_addr (x_in),
    .rd_data (ram_mid)
  );

  sgm_kernel u_kernel (
    .left_col   (win_c2_r),
    .center_col (win_c1_r),
    .right_col  (cur_col),
    .magnitude  (kern_mag)
  );

  // --------------------------------------------------------------------------
  // output register, plus the pending row-end zero
  // --------------------------------------------------------------------------
  pixel_t out_mag_r;
  logic   out_row_end_r, out_frame_end_r, out_run_last_r;
  logic   pend_fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (s1_go && s1_has_res_r) begin
      out_valid_r <= 1'b1;
      pend_r      <= s1_last_col_r;
    end else if (out_fire && pend_r) begin
      out_valid_r <= 1'b1;
      pend_r      <= 1'b0;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_has_res_r) begin
      out_mag_r       <= s1_interior_r ? kern_mag : '0;
      out_row_end_r   <= 1'b0;
      out_frame_end_r <= 1'b0;
      out_run_last_r  <= !s1_last_col_r;
      pend_fe_r       <= s1_last_row_r;
    end else if (out_fire && pend_r) begin
      out_mag_r       <= '0;
      out_row_end_r   <= 1'b1;
      out_frame_end_r <= pend_fe_r;
      out_run_last_r  <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_magnitude = out_mag_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;
  assign out_run_last  = out_run_last_r;

`ifndef NO_ASSERTIONS
  // a pending row-end zero always sits behind a shown result
  a_pend_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r)
    else $error("pending row-end result without a valid output");

  // a stuck stage 1 item must block the input
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |-> !in_ready)
    else $error("input accepted while stage 1 is stalled");

  // frame end only on the row-end zero
  a_frame_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_end_r) |-> (out_row_end_r && out_run_last_r && out_mag_r == '0))
    else $error("frame_end on a result that is not a row-end zero");

  // a non-final result is followed at once by its row-end zero
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_run_last_r) |=> (out_valid_r && out_row_end_r && !pend_r))
    else $error("row-end zero did not follow its interior result");
`endif

endmodule

`default_nettype wire
